// ===== hdl/nafb_pkg.sv =====
// Shared types, constants and frame helpers of the neighbor advertisement frame builder.
`default_nettype none

package nafb_pkg;

   localparam int MAC_WIDTH     = 48;
   localparam int ADDR_WIDTH    = 128;
   localparam int WORD_WIDTH    = 64;
   localparam int BEAT_COUNT    = 11;
   localparam int FRAME_BITS    = BEAT_COUNT * WORD_WIDTH;
   localparam int BEAT_CNT_W    = $clog2(BEAT_COUNT);
   localparam int GAP_WIDTH     = $clog2(BEAT_COUNT);
   localparam int CSUM_WIDTH    = 16;
   localparam int ADDR_SUM_W    = 19;
   localparam int MAC_SUM_W     = 18;
   localparam int TOTAL_SUM_W   = 21;

   localparam logic [BEAT_CNT_W-1:0] LAST_BEAT_IDX  = BEAT_CNT_W'(BEAT_COUNT - 1);
   localparam logic [GAP_WIDTH-1:0]  ITEM_GAP       = GAP_WIDTH'(BEAT_COUNT - 1);
   localparam logic [3:0]            FULL_BEAT_BYTES = 4'd8;
   localparam logic [3:0]            LAST_BEAT_BYTES = 4'd6;

   localparam logic [ADDR_WIDTH-1:0] ALL_NODES_ADDR = {64'hFF02_0000_0000_0000, 64'd1};
   localparam logic [MAC_WIDTH-1:0]  ALL_NODES_MAC  = 48'h3333_0000_0001;

   localparam logic [7:0] HOPS_MAX       = 8'd255;
   localparam logic [7:0] NEXT_HDR_ICMP  = 8'd58;
   localparam logic [7:0] ICMP_TYPE_NA   = 8'd136;
   localparam logic [7:0] FLAGS_DAD      = 8'h20;
   localparam logic [7:0] FLAGS_UNICAST  = 8'h60;
   localparam logic [15:0] ICMP_LEN      = 16'd32;
   // Constant checksum words: upper-layer length plus next header, ICMP type/code
   // and the option type/length.
   localparam logic [TOTAL_SUM_W-1:0] CSUM_CONST = 21'h0_8A5B;

   typedef enum logic [0:0] {
      CSR_LOCAL_MAC  = 1'b0,
      CSR_LINK_READY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] target;
      logic [ADDR_WIDTH-1:0] sender;
      logic [MAC_WIDTH-1:0]  requester_mac;
      logic [MAC_WIDTH-1:0]  local_mac;
   } nafb_req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] target;
      logic [ADDR_WIDTH-1:0] dst;
      logic [MAC_WIDTH-1:0]  dst_mac;
      logic [MAC_WIDTH-1:0]  src_mac;
      logic                  dad;
   } nafb_item_type;

   function automatic logic [ADDR_SUM_W-1:0] sum_addr_words(input logic [ADDR_WIDTH-1:0] a);
      logic [ADDR_SUM_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < ADDR_WIDTH / 16; i++) begin
         acc = acc + ADDR_SUM_W'(a[16*i +: 16]);
      end
      return acc;
   endfunction

   function automatic logic [MAC_SUM_W-1:0] sum_mac_words(input logic [MAC_WIDTH-1:0] m);
      return MAC_SUM_W'(m[47:32]) + MAC_SUM_W'(m[31:16]) + MAC_SUM_W'(m[15:0]);
   endfunction

   function automatic logic [FRAME_BITS-1:0] build_frame(input nafb_item_type it,
                                                         input logic [CSUM_WIDTH-1:0] csum);
      return {it.dst_mac, it.src_mac, 16'h86DD,
              8'h60, 8'h00, 8'h00, 8'h00, ICMP_LEN, NEXT_HDR_ICMP, HOPS_MAX,
              it.target, it.dst,
              ICMP_TYPE_NA, 8'h00, csum, (it.dad ? FLAGS_DAD : FLAGS_UNICAST), 24'd0,
              it.target, 8'd2, 8'd1, it.src_mac, 16'd0};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/nafb_csum_pipe.sv =====
// Four-stage pipeline that resolves the destination and computes the ICMPv6 checksum.
`default_nettype none

module nafb_csum_pipe
   import nafb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire nafb_req_type          in_req,
   output logic                       out_valid,
   output nafb_item_type              out_item,
   output logic [CSUM_WIDTH-1:0]      out_csum
);

   // Stage A: captured request.
   logic                     a_valid_ff;
   nafb_req_type             a_req_ff;
   // Stage B: destination chosen, per-field partial sums.
   logic                     b_valid_ff;
   nafb_item_type            b_item_ff;
   logic [ADDR_SUM_W-1:0]    b_tsum_ff;
   logic [ADDR_SUM_W-1:0]    b_dsum_ff;
   logic [MAC_SUM_W-1:0]     b_msum_ff;
   // Stage C: full one's complement accumulator before folding.
   logic                     c_valid_ff;
   nafb_item_type            c_item_ff;
   logic [TOTAL_SUM_W-1:0]   c_total_ff;
   // Stage D: folded and inverted checksum.
   logic                     d_valid_ff;
   nafb_item_type            d_item_ff;
   logic [CSUM_WIDTH-1:0]    d_csum_ff;

   nafb_item_type            b_item_in;
   logic [TOTAL_SUM_W-1:0]   c_total_in;
   logic [16:0]              fold1;
   logic [15:0]              fold2;

   always_comb begin
      b_item_in.dad     = (a_req_ff.sender == '0);
      b_item_in.target  = a_req_ff.target;
      b_item_in.src_mac = a_req_ff.local_mac;
      b_item_in.dst     = b_item_in.dad ? ALL_NODES_ADDR : a_req_ff.sender;
      b_item_in.dst_mac = b_item_in.dad ? ALL_NODES_MAC : a_req_ff.requester_mac;
   end

   // The target appears in both the pseudo-header and the message, hence doubled.
   assign c_total_in = TOTAL_SUM_W'({b_tsum_ff, 1'b0}) + TOTAL_SUM_W'(b_dsum_ff)
                     + TOTAL_SUM_W'(b_msum_ff) + CSUM_CONST
                     + TOTAL_SUM_W'({(b_item_ff.dad ? FLAGS_DAD : FLAGS_UNICAST), 8'h00});

   // Two folds suffice: after the first the carry is at most one and cannot ripple out.
   assign fold1 = 17'(c_total_ff[15:0]) + 17'(c_total_ff[TOTAL_SUM_W-1:16]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);

   always_ff @(posedge clock) begin
      a_req_ff   <= in_req;
      b_item_ff  <= b_item_in;
      b_tsum_ff  <= sum_addr_words(a_req_ff.target);
      b_dsum_ff  <= sum_addr_words(b_item_in.dst);
      b_msum_ff  <= sum_mac_words(a_req_ff.local_mac);
      c_item_ff  <= b_item_ff;
      c_total_ff <= c_total_in;
      d_item_ff  <= c_item_ff;
      d_csum_ff  <= ~fold2;
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = d_item_ff;
   assign out_csum  = d_csum_ff;

endmodule

`default_nettype wire

// ===== hdl/neighbor_advert_frame_builder_unit.sv =====
// Top level of the IPv6 neighbor advertisement frame builder.
//
//   channel   ports                          handshake
//   request   start, busy, req_*             accepted when start && !busy
//   response  rsp_strobe, rsp_*              one beat per strobe cycle, no backpressure
//   config    csr_valid, csr_ready, csr_*    written when csr_valid && csr_ready
//
// An item that yields a frame produces eleven beats on consecutive cycles, the first
// one after the four checksum stages, the frame load and the output register.
// The beat serializer sets the rate: after such an item busy stays high until a new
// frame could no longer overrun it, so frames taken at once leave back to back.
// Items that yield no frame (link down, requester MAC missing) keep busy low.
// Synchronous reset clears the registers, the pipeline valids and the serializer.
`default_nettype none

module neighbor_advert_frame_builder_unit
   import nafb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [WORD_WIDTH-1:0]  req_target_high,
   input  wire logic [WORD_WIDTH-1:0]  req_target_low,
   input  wire logic [WORD_WIDTH-1:0]  req_sender_high,
   input  wire logic [WORD_WIDTH-1:0]  req_sender_low,
   input  wire logic [MAC_WIDTH-1:0]   req_requester_mac,
   input  wire logic                   req_requester_mac_valid,
   output logic                        rsp_strobe,
   output logic [WORD_WIDTH-1:0]       rsp_frame_word,
   output logic [3:0]                  rsp_valid_bytes,
   output logic                        rsp_last_beat,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire csr_index_type          csr_index,
   input  wire logic [MAC_WIDTH-1:0]   csr_data
);

   logic [MAC_WIDTH-1:0]    local_mac_ff;
   logic                    link_ready_ff;
   logic [GAP_WIDTH-1:0]    gap_ff;

   logic                    accept;
   logic                    produce;
   nafb_req_type            req;

   logic                    pipe_valid;
   nafb_item_type           pipe_item;
   logic [CSUM_WIDTH-1:0]   pipe_csum;

   logic [FRAME_BITS-1:0]   frame_ff;
   logic [BEAT_CNT_W-1:0]   beat_ff;
   logic                    active_ff;
   logic                    rsp_strobe_ff;
   logic [WORD_WIDTH-1:0]   rsp_word_ff;
   logic [3:0]              rsp_bytes_ff;
   logic                    rsp_last_ff;
   logic                    at_last;

   assign csr_ready = 1'b1;
   assign busy      = (gap_ff != '0);
   assign accept    = start && !busy;
   assign produce   = accept && link_ready_ff && req_requester_mac_valid;

   assign req.target        = {req_target_high, req_target_low};
   assign req.sender        = {req_sender_high, req_sender_low};
   assign req.requester_mac = req_requester_mac;
   assign req.local_mac     = local_mac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_mac_ff  <= '0;
         link_ready_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOCAL_MAC:  local_mac_ff  <= csr_data;
            CSR_LINK_READY: link_ready_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // A taken item that will emit a frame reloads the gap counter, and busy holds the input
   // until it runs out, which keeps the serializer from ever being overrun.
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (produce) begin
         gap_ff <= ITEM_GAP;
      end else if (gap_ff != '0) begin
         gap_ff <= gap_ff - 1'b1;
      end
   end

   nafb_csum_pipe u_csum_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (produce),
      .in_req    (req),
      .out_valid (pipe_valid),
      .out_item  (pipe_item),
      .out_csum  (pipe_csum)
   );

   assign at_last = (beat_ff == LAST_BEAT_IDX);

   // A new frame can arrive no earlier than the cycle in which the previous frame's last
   // beat leaves, so loading and emitting never collide.
   always_ff @(posedge clock) begin
      if (pipe_valid) begin
         frame_ff <= build_frame(pipe_item, pipe_csum);
      end else if (active_ff) begin
         frame_ff <= frame_ff << WORD_WIDTH;
      end
      rsp_word_ff  <= frame_ff[FRAME_BITS-1 -: WORD_WIDTH];
      rsp_bytes_ff <= at_last ? LAST_BEAT_BYTES : FULL_BEAT_BYTES;
      rsp_last_ff  <= active_ff && at_last;
      if (reset) begin
         active_ff     <= 1'b0;
         beat_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= active_ff;
         if (pipe_valid) begin
            active_ff <= 1'b1;
            beat_ff   <= '0;
         end else if (active_ff) begin
            beat_ff <= beat_ff + 1'b1;
            if (at_last) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_frame_word  = rsp_word_ff;
   assign rsp_valid_bytes = rsp_bytes_ff;
   assign rsp_last_beat   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/nafb_checker.sv =====
// Port-level checker of the frame builder and its bind to the top level.
`default_nettype none

module nafb_checker
   import nafb_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  req_requester_mac_valid,
   input wire logic                  rsp_strobe,
   input wire logic [WORD_WIDTH-1:0] rsp_frame_word,
   input wire logic [3:0]            rsp_valid_bytes,
   input wire logic                  rsp_last_beat
);

   // Beats of one frame leave on consecutive cycles.
   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_beat |=> rsp_strobe)
      else $error("frame beats are not contiguous");

   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_last_beat ? rsp_valid_bytes == LAST_BEAT_BYTES
                                    : rsp_valid_bytes == FULL_BEAT_BYTES))
      else $error("valid byte count does not match beat position");

   a_last_padding: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_beat |-> rsp_frame_word[15:0] == 16'd0)
      else $error("padding of the last beat is not zero");

   // Busy rises only after an item was taken.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted item");

   // An item without a requester MAC never yields a frame, so it sets no busy time.
   a_no_mac_no_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_requester_mac_valid |=> !busy)
      else $error("item without requester MAC made the block busy");

endmodule

bind neighbor_advert_frame_builder_unit nafb_checker u_nafb_checker (
   .clock                   (clock),
   .reset                   (reset),
   .start                   (start),
   .busy                    (busy),
   .req_requester_mac_valid (req_requester_mac_valid),
   .rsp_strobe              (rsp_strobe),
   .rsp_frame_word          (rsp_frame_word),
   .rsp_valid_bytes         (rsp_valid_bytes),
   .rsp_last_beat           (rsp_last_beat)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the IPv6 neighbor advertisement frame builder.
`timescale 1ns / 1ps

module testbench
   import nafb_pkg::*;
();

   localparam int          FRAME_BYTES        = 86;
   localparam int          BEATS_PER_FRAME    = 11;
   localparam int          BYTES_PER_BEAT     = 8;
   localparam int          FRAME_VEC_BITS     = BEATS_PER_FRAME * BYTES_PER_BEAT * 8;
   localparam int          IP_SRC_OFFSET      = 22;
   localparam int          CSUM_OFFSET        = 56;
   localparam logic [15:0] ETHERTYPE_IPV6     = 16'h86DD;
   localparam logic [31:0] IPV6_VERSION_WORD  = 32'h6000_0000;
   localparam logic [15:0] ICMP_PAYLOAD_LEN   = 16'd32;
   localparam logic [7:0]  NEXT_HDR_ICMPV6    = 8'd58;
   localparam logic [7:0]  REPLY_HOPS         = 8'd255;
   localparam logic [7:0]  ICMP_NEIGHBOR_ADV  = 8'd136;
   localparam logic [7:0]  OPT_TARGET_LLADDR  = 8'd2;
   localparam logic [7:0]  OPT_LEN_UNITS      = 8'd1;
   localparam logic [7:0]  FLAGS_OVERRIDE     = 8'h20;
   localparam logic [7:0]  FLAGS_SOL_OVERRIDE = 8'h60;
   localparam logic [127:0] ALL_NODES_IP      = {64'hFF02_0000_0000_0000, 64'd1};
   localparam logic [47:0]  ALL_NODES_ETH     = 48'h3333_0000_0001;
   localparam logic [63:0]  ALL_ONES_64       = '1;
   localparam int          SETTLE_CYCLES      = 24;
   localparam int          CYCLE_LIMIT        = 200000;
   localparam int          MAX_REPORTS        = 10;

   typedef struct {
      logic [63:0] target_high;
      logic [63:0] target_low;
      logic [63:0] sender_high;
      logic [63:0] sender_low;
      logic [47:0] requester_mac;
      logic        requester_mac_valid;
   } solicitation_type;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } frame_beat_type;

   class advert_scoreboard;
      logic [47:0]     local_mac;
      logic            link_ready;
      frame_beat_type  pending_beats[$];
      int              error_count;

      function new();
         local_mac   = '0;
         link_ready  = 1'b0;
         error_count = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [47:0] value);
         if (idx == CSR_LOCAL_MAC) begin
            local_mac = value;
         end else if (idx == CSR_LINK_READY) begin
            link_ready = value[0];
         end
      endfunction

      // Builds the whole advertisement for one accepted solicitation that yields a frame and queues its beats.
      function void note_solicitation(solicitation_type s);
         logic [FRAME_VEC_BITS-1:0] frame;
         logic [127:0]              reply_dst_ip;
         logic [47:0]               dst_mac;
         logic [7:0]                flags;
         logic [31:0]               acc;
         frame_beat_type            beat;
         if (!link_ready || !s.requester_mac_valid) return;
         if ({s.sender_high, s.sender_low} == '0) begin
            reply_dst_ip = ALL_NODES_IP;
            dst_mac      = ALL_NODES_ETH;
            flags        = FLAGS_OVERRIDE;
         end else begin
            reply_dst_ip = {s.sender_high, s.sender_low};
            dst_mac      = s.requester_mac;
            flags        = FLAGS_SOL_OVERRIDE;
         end
         frame = {dst_mac, local_mac, ETHERTYPE_IPV6,
                  IPV6_VERSION_WORD, ICMP_PAYLOAD_LEN, NEXT_HDR_ICMPV6, REPLY_HOPS,
                  s.target_high, s.target_low, reply_dst_ip,
                  ICMP_NEIGHBOR_ADV, 8'd0, 16'd0, flags, 24'd0,
                  s.target_high, s.target_low,
                  OPT_TARGET_LLADDR, OPT_LEN_UNITS, local_mac, 16'd0};
         // The pseudo-header addresses and the ICMPv6 message sit back to back in the
         // frame, so one pass over bytes 22 to 85 covers both.
         acc = 32'(ICMP_PAYLOAD_LEN) + 32'(NEXT_HDR_ICMPV6);
         for (int b = IP_SRC_OFFSET; b < FRAME_BYTES; b += 2) begin
            acc = acc + 32'(frame[FRAME_VEC_BITS - 1 - 8 * b -: 16]);
         end
         while (acc[31:16] != 16'd0) begin
            acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
         end
         frame[FRAME_VEC_BITS - 1 - 8 * CSUM_OFFSET -: 16] = ~acc[15:0];
         for (int k = 0; k < BEATS_PER_FRAME; k++) begin
            beat.word   = frame[FRAME_VEC_BITS - 1 - 64 * k -: 64];
            beat.last   = (k == BEATS_PER_FRAME - 1);
            beat.nbytes = beat.last ? 4'(FRAME_BYTES - BYTES_PER_BEAT * (BEATS_PER_FRAME - 1))
                                    : 4'(BYTES_PER_BEAT);
            pending_beats.push_back(beat);
         end
      endfunction

      function void check_beat(logic [63:0] word, logic [3:0] nbytes, logic last);
         frame_beat_type want;
         if (pending_beats.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected beat: word=%h bytes=%0d last=%b", word, nbytes, last);
            return;
         end
         want = pending_beats.pop_front();
         if (word !== want.word || nbytes !== want.nbytes || last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display({"beat mismatch: expected word=%h bytes=%0d last=%b,",
                         " got word=%h bytes=%0d last=%b"},
                        want.word, want.nbytes, want.last, word, nbytes, last);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [63:0]        req_target_high;
   logic [63:0]        req_target_low;
   logic [63:0]        req_sender_high;
   logic [63:0]        req_sender_low;
   logic [47:0]        req_requester_mac;
   logic               req_requester_mac_valid;
   logic               rsp_strobe;
   logic [63:0]        rsp_frame_word;
   logic [3:0]         rsp_valid_bytes;
   logic               rsp_last_beat;
   logic               csr_valid;
   logic               csr_ready;
   csr_index_type      csr_index;
   logic [47:0]        csr_data;

   advert_scoreboard   sb;
   int                 cycle_count;

   neighbor_advert_frame_builder_unit u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_target_high         (req_target_high),
      .req_target_low          (req_target_low),
      .req_sender_high         (req_sender_high),
      .req_sender_low          (req_sender_low),
      .req_requester_mac       (req_requester_mac),
      .req_requester_mac_valid (req_requester_mac_valid),
      .rsp_strobe              (rsp_strobe),
      .rsp_frame_word          (rsp_frame_word),
      .rsp_valid_bytes         (rsp_valid_bytes),
      .rsp_last_beat           (rsp_last_beat),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_register(csr_index, csr_data);
         end
         if (start && !busy) begin
            sb.note_solicitation('{target_high: req_target_high,
                                   target_low: req_target_low,
                                   sender_high: req_sender_high,
                                   sender_low: req_sender_low,
                                   requester_mac: req_requester_mac,
                                   requester_mac_valid: req_requester_mac_valid});
         end
         if (rsp_strobe) begin
            sb.check_beat(rsp_frame_word, rsp_valid_bytes, rsp_last_beat);
         end
      end
   end

   function automatic logic [63:0] random_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return ALL_ONES_64;
      return {$urandom, $urandom};
   endfunction

   function automatic solicitation_type make_solicitation(logic [63:0] th, logic [63:0] tl,
                                                          logic [63:0] sh, logic [63:0] sl,
                                                          logic [47:0] mac, logic mac_ok);
      solicitation_type s;
      s.target_high         = th;
      s.target_low          = tl;
      s.sender_high         = sh;
      s.sender_low          = sl;
      s.requester_mac       = mac;
      s.requester_mac_valid = mac_ok;
      return s;
   endfunction

   // Mostly well-formed solicitations; some DAD probes, some with one address half zero,
   // and a few without a requester MAC.
   function automatic solicitation_type random_solicitation();
      solicitation_type s;
      int               shape;
      s.target_high         = random_word();
      s.target_low          = random_word();
      s.requester_mac       = 48'(random_word());
      s.requester_mac_valid = ($urandom_range(0, 9) != 0);
      shape = $urandom_range(0, 9);
      s.sender_high = (shape <= 2) ? '0 : random_word();
      s.sender_low  = (shape <= 1 || shape == 3) ? '0 : random_word();
      return s;
   endfunction

   task automatic send_solicitation(solicitation_type s);
      start                   <= 1'b1;
      req_target_high         <= s.target_high;
      req_target_low          <= s.target_low;
      req_sender_high         <= s.sender_high;
      req_sender_low          <= s.sender_low;
      req_requester_mac       <= s.requester_mac;
      req_requester_mac_valid <= s.requester_mac_valid;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(csr_index_type idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      while (sb.pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count, bit with_gaps);
      for (int i = 0; i < count; i++) begin
         send_solicitation(random_solicitation());
         if (with_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
      start <= 1'b0;
   endtask

   task automatic run_directed();
      logic [47:0] mac;
      mac = 48'({$urandom, $urandom});
      send_solicitation(make_solicitation('0, '0, '0, '0, '0, 1'b1));
      send_solicitation(make_solicitation(ALL_ONES_64, ALL_ONES_64, '0, '0, '1, 1'b1));
      send_solicitation(make_solicitation(random_word(), random_word(), '0, '0, mac, 1'b0));
      send_solicitation(make_solicitation(ALL_ONES_64, ALL_ONES_64, ALL_ONES_64, ALL_ONES_64,
                                          '1, 1'b1));
      send_solicitation(make_solicitation({$urandom, $urandom}, {$urandom, $urandom},
                                          '0, 64'd1, mac, 1'b1));
      send_solicitation(make_solicitation({$urandom, $urandom}, {$urandom, $urandom},
                                          64'hFE80_0000_0000_0000, '0, mac, 1'b1));
      send_solicitation(make_solicitation({$urandom, $urandom}, {$urandom, $urandom},
                                          {$urandom, $urandom}, {$urandom, $urandom},
                                          mac, 1'b0));
      send_solicitation(make_solicitation('0, '0, {$urandom, $urandom}, {$urandom, $urandom},
                                          '0, 1'b1));
      send_solicitation(make_solicitation('0, '0, ALL_ONES_64, ALL_ONES_64, '1, 1'b0));
      send_solicitation(make_solicitation(ALL_ONES_64, '0, '0, ALL_ONES_64, mac, 1'b1));
      for (int i = 0; i < 10; i++) begin
         send_solicitation(random_solicitation());
      end
      start <= 1'b0;
   endtask

   initial begin
      sb                      = new();
      cycle_count             = 0;
      clock                   = 1'b0;
      reset                   = 1'b1;
      start                   = 1'b0;
      req_target_high         = '0;
      req_target_low          = '0;
      req_sender_high         = '0;
      req_sender_low          = '0;
      req_requester_mac       = '0;
      req_requester_mac_valid = 1'b0;
      csr_valid               = 1'b0;
      csr_index               = CSR_LOCAL_MAC;
      csr_data                = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Registers are still at reset here, so the link is down and nothing comes back.
      run_random(4, 1'b1);
      settle();

      write_csr(CSR_LOCAL_MAC, 48'({$urandom, $urandom}));
      write_csr(CSR_LINK_READY, 48'({$urandom, $urandom}) | 48'd1);
      run_directed();
      settle();

      write_csr(CSR_LOCAL_MAC, '0);
      run_random(30, 1'b1);
      settle();

      write_csr(CSR_LOCAL_MAC, '1);
      run_random(30, 1'b1);
      settle();

      // Upper data bits set with bit zero clear still take the link down.
      write_csr(CSR_LINK_READY, 48'({$urandom, $urandom}) & ~48'd1);
      write_csr(CSR_LOCAL_MAC, 48'({$urandom, $urandom}));
      run_random(15, 1'b1);
      settle();

      write_csr(CSR_LINK_READY, 48'd1);
      write_csr(CSR_LOCAL_MAC, 48'({$urandom, $urandom}));
      run_random(70, 1'b0);
      settle();

      if (sb.error_count == 0 && sb.pending_beats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/nafb_pkg.sv
hdl/nafb_csum_pipe.sv
hdl/neighbor_advert_frame_builder_unit.sv
hdl/nafb_checker.sv
tb/testbench.sv
